### sv/tgms_pkg.sv
// ----------------------------------------------------------------------------
// tgms_pkg
// shared types, codes and saturation helper for the triangular gram solver
// ----------------------------------------------------------------------------
`default_nettype none

package tgms_pkg;

  localparam int unsigned MAX_DIM_DEF = 16;
  localparam logic [4:0]  SIZE_RST    = 5'd16;

  // input word kinds
  localparam logic [1:0] KIND_WR_A    = 2'd0;
  localparam logic [1:0] KIND_WR_B    = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;
  localparam logic [1:0] KIND_RD_C    = 2'd3;

  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] element;
    logic [3:0]         out_row;
    logic [3:0]         out_col;
  } out_word_t;

  // which product a mac step forms
  typedef enum logic [1:0] {
    OP_F = 2'd0,
    OP_D = 2'd1,
    OP_E = 2'd2
  } op_e;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    op_e  op;
  } tag_t;

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    if (v > 49'(SAT_MAX)) return SAT_MAX;
    if (v < 49'(SAT_MIN)) return SAT_MIN;
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

### sv/tgms_mac.sv
// ----------------------------------------------------------------------------
// tgms_mac
// q16.16 multiply stage and saturating accumulate stage
// ----------------------------------------------------------------------------
`default_nettype none

module tgms_mac (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire logic signed [31:0]  x_i,
  input  wire logic signed [31:0]  y_i,
  input  wire tgms_pkg::tag_t      tag_i,
  output logic signed [31:0]       acc_o,
  output tgms_pkg::tag_t           tag_o
);

  logic signed [63:0] full;
  logic signed [47:0] prod_d, prod_q;
  logic signed [31:0] acc_d, acc_q;
  tgms_pkg::tag_t     tag2_q, tag3_q;

  assign full   = x_i * y_i;
  // arithmetic shift right by 16
  assign prod_d = full[63:16];

  always_comb begin
    if (tag2_q.first) begin
      acc_d = tgms_pkg::sat32(49'(prod_q));
    end else begin
      acc_d = tgms_pkg::sat32(49'(acc_q) + 49'(prod_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag2_q <= tag_i;
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (tag2_q.valid) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;
  assign tag_o = tag3_q;

endmodule

`default_nettype wire

### sv/triangular_gram_matrix_solver.sv
// ----------------------------------------------------------------------------
// triangular_gram_matrix_solver
// loads A and B, computes C = B*A*A' + B'*B in q16.16, returns C elements
// ----------------------------------------------------------------------------
// A user loads A (upper triangle) and B one word per cycle unless stalled,
// then sends a compute word, then reads C one word at a time. A read goes
// into a pending stage with its memory read and its result is offered
// through an output register, so reads stream one per cycle while the sink
// keeps up. A compute word walks the stores through a single multiply and
// accumulate pipeline, one product per cycle: N*N*(N+1)/2 steps for B*A,
// the same for the product with A', N*N*N for B'*B, plus a drain after the
// B*A pass and one at the end, where N is the active size. No word is taken
// during compute. After reset the result store is cleared, one entry per
// cycle, before the first word is taken. Products truncate toward minus
// infinity and every sum saturates to 32 bits.
`default_nettype none

module triangular_gram_matrix_solver #(
  parameter int unsigned MAX_DIM = tgms_pkg::MAX_DIM_DEF
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cfg_we_i,
  input  wire logic [4:0]            cfg_wdata_i,
  input  wire                        in_valid_i,
  output logic                       in_stall_o,
  input  wire tgms_pkg::in_word_t    in_word_i,
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output tgms_pkg::out_word_t        out_word_o
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned DW    = $clog2(MAX_DIM);
  localparam int unsigned NW    = $clog2(MAX_DIM + 1);
  localparam logic [AW-1:0] CLR_LAST   = AW'(DEPTH - 1);
  localparam logic [2:0]    DRAIN_LAST = 3'd3;

  // sequencer states
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CLEAR  = 7'b0000010,
    ST_FMUL   = 7'b0000100,
    ST_FDRAIN = 7'b0001000,
    ST_DMUL   = 7'b0010000,
    ST_EMUL   = 7'b0100000,
    ST_EDRAIN = 7'b1000000
  } state_e;

  function automatic logic [AW-1:0] addr_f(input int unsigned r, input int unsigned c);
    return AW'(r * MAX_DIM + c);
  endfunction

  // storage
  logic [31:0] a_mem [DEPTH];
  logic [31:0] b_mem [DEPTH];
  logic [31:0] p_mem [DEPTH];
  logic [31:0] r_mem [DEPTH];

  state_e          state_q, state_d;
  logic [DW-1:0]   i_q, i_d, j_q, j_d, k_q, k_d;
  logic [2:0]      drain_q, drain_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [4:0]      msz_q;

  // active size, clamped to 1..MAX_DIM
  logic [NW-1:0]   n_act;
  logic [DW-1:0]   nm1;
  logic            in_rng;
  logic            in_acc;
  logic [AW-1:0]   in_addr;

  always_comb begin
    if (msz_q == 5'd0) begin
      n_act = NW'(1);
    end else if (32'(msz_q) > MAX_DIM) begin
      n_act = NW'(MAX_DIM);
    end else begin
      n_act = NW'(msz_q);
    end
  end

  assign nm1     = DW'(n_act - NW'(1));
  assign in_rng  = (32'(in_word_i.row) < 32'(n_act)) && (32'(in_word_i.col) < 32'(n_act));
  assign in_addr = addr_f(32'(in_word_i.row), 32'(in_word_i.col));

  // read word path: memory read stage then output register
  logic                p_valid_q, p_inside_q;
  logic [3:0]          p_row_q, p_col_q;
  logic [31:0]         r_rd_q;
  logic                out_valid_q;
  tgms_pkg::out_word_t out_word_q;
  logic                p_move;

  // compute can only start from idle; a new word waits if a pending read has no room
  assign in_stall_o = (state_q != ST_IDLE) || (p_valid_q && out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign p_move     = p_valid_q && (!out_valid_q || !out_stall_i);

  // issue stage: addresses and tag come straight from the loop counters
  tgms_pkg::tag_t tag0;
  logic [AW-1:0]  a_raddr, b_raddr1, b_raddr2, p_raddr, w_addr0;

  always_comb begin
    tag0     = '0;
    a_raddr  = addr_f(32'(k_q), 32'(j_q));
    b_raddr1 = addr_f(32'(i_q), 32'(k_q));
    b_raddr2 = addr_f(32'(k_q), 32'(j_q));
    p_raddr  = addr_f(32'(i_q), 32'(k_q));
    w_addr0  = addr_f(32'(i_q), 32'(j_q));
    unique case (state_q)
      ST_FMUL: begin
        // B*A, A upper triangular: k runs 0..j
        tag0 = '{valid: 1'b1, first: (k_q == '0), last: (k_q == j_q), op: tgms_pkg::OP_F};
      end
      ST_DMUL: begin
        // (B*A)*A': k runs j..n-1 and uses A[j][k]
        a_raddr = addr_f(32'(j_q), 32'(k_q));
        tag0 = '{valid: 1'b1, first: (k_q == j_q), last: (k_q == nm1), op: tgms_pkg::OP_D};
      end
      ST_EMUL: begin
        // B'*B uses B[k][i] and B[k][j]
        b_raddr1 = addr_f(32'(k_q), 32'(i_q));
        tag0 = '{valid: 1'b1, first: (k_q == '0), last: (k_q == nm1), op: tgms_pkg::OP_E};
      end
      ST_IDLE, ST_CLEAR, ST_FDRAIN, ST_EDRAIN: begin
        tag0 = '0;
      end
      default: begin
        tag0 = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    drain_d = drain_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && (in_word_i.kind == tgms_pkg::KIND_COMPUTE)) begin
          state_d = ST_FMUL;
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
        end
      end
      ST_FMUL: begin
        if (k_q == j_q) begin
          k_d = '0;
          if (j_q == nm1) begin
            j_d = '0;
            if (i_q == nm1) begin
              state_d = ST_FDRAIN;
              drain_d = '0;
            end else begin
              i_d = i_q + DW'(1);
            end
          end else begin
            j_d = j_q + DW'(1);
          end
        end else begin
          k_d = k_q + DW'(1);
        end
      end
      ST_FDRAIN: begin
        // let the last partial words land before they are read back
        drain_d = drain_q + 3'd1;
        if (drain_q == DRAIN_LAST) begin
          state_d = ST_DMUL;
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
        end
      end
      ST_DMUL: begin
        if (k_q == nm1) begin
          state_d = ST_EMUL;
          k_d     = '0;
        end else begin
          k_d = k_q + DW'(1);
        end
      end
      ST_EMUL: begin
        if (k_q == nm1) begin
          if (j_q == nm1) begin
            if (i_q == nm1) begin
              state_d = ST_EDRAIN;
              drain_d = '0;
            end else begin
              state_d = ST_DMUL;
              i_d     = i_q + DW'(1);
              j_d     = '0;
              k_d     = '0;
            end
          end else begin
            state_d = ST_DMUL;
            j_d     = j_q + DW'(1);
            k_d     = j_q + DW'(1);
          end
        end else begin
          k_d = k_q + DW'(1);
        end
      end
      ST_EDRAIN: begin
        drain_d = drain_q + 3'd1;
        if (drain_q == DRAIN_LAST) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      drain_q <= '0;
      clr_q   <= '0;
      msz_q   <= tgms_pkg::SIZE_RST;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      drain_q <= drain_d;
      clr_q   <= clr_d;
      if (cfg_we_i) begin
        msz_q <= cfg_wdata_i;
      end
    end
  end

  // memory reads, registered
  logic [31:0]    a_rd_q, b_rd1_q, b_rd2_q, p_rd_q;
  tgms_pkg::tag_t tag1_q;
  logic [AW-1:0]  w_addr1_q, w_addr2_q, w_addr3_q;

  always_ff @(posedge clk_i) begin
    a_rd_q  <= a_mem[a_raddr];
    b_rd1_q <= b_mem[b_raddr1];
    b_rd2_q <= b_mem[b_raddr2];
    p_rd_q  <= p_mem[p_raddr];
    if (in_acc && (in_word_i.kind == tgms_pkg::KIND_RD_C)) begin
      r_rd_q <= r_mem[in_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
    end else begin
      tag1_q <= tag0;
    end
  end

  // write address follows its step down the pipe
  always_ff @(posedge clk_i) begin
    w_addr1_q <= w_addr0;
    w_addr2_q <= w_addr1_q;
    w_addr3_q <= w_addr2_q;
  end

  // operand select
  logic signed [31:0] mac_x, mac_y, acc;
  tgms_pkg::tag_t     tag3;

  always_comb begin
    case (tag1_q.op)
      tgms_pkg::OP_F: begin
        mac_x = b_rd1_q;
        mac_y = a_rd_q;
      end
      tgms_pkg::OP_D: begin
        mac_x = p_rd_q;
        mac_y = a_rd_q;
      end
      tgms_pkg::OP_E: begin
        mac_x = b_rd1_q;
        mac_y = b_rd2_q;
      end
      default: begin
        mac_x = b_rd1_q;
        mac_y = a_rd_q;
      end
    endcase
  end

  tgms_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .x_i    (mac_x),
    .y_i    (mac_y),
    .tag_i  (tag1_q),
    .acc_o  (acc),
    .tag_o  (tag3)
  );

  // hold the finished A' product while B'*B accumulates
  logic signed [31:0] d_q;
  logic               f_wr, e_wr;

  assign f_wr = tag3.valid && tag3.last && (tag3.op == tgms_pkg::OP_F);
  assign e_wr = tag3.valid && tag3.last && (tag3.op == tgms_pkg::OP_E);

  always_ff @(posedge clk_i) begin
    if (tag3.valid && tag3.last && (tag3.op == tgms_pkg::OP_D)) begin
      d_q <= acc;
    end
  end

  // memory writes
  always_ff @(posedge clk_i) begin
    if (in_acc && in_rng && (in_word_i.kind == tgms_pkg::KIND_WR_A)) begin
      a_mem[in_addr] <= in_word_i.value;
    end
    if (in_acc && in_rng && (in_word_i.kind == tgms_pkg::KIND_WR_B)) begin
      b_mem[in_addr] <= in_word_i.value;
    end
    if (f_wr) begin
      p_mem[w_addr3_q] <= acc;
    end
    if (state_q == ST_CLEAR) begin
      r_mem[clr_q] <= '0;
    end else if (e_wr) begin
      r_mem[w_addr3_q] <= tgms_pkg::sat32(49'(d_q) + 49'(acc));
    end
  end

  // read words: pending stage and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc && (in_word_i.kind == tgms_pkg::KIND_RD_C)) begin
        p_valid_q <= 1'b1;
      end else if (p_move) begin
        p_valid_q <= 1'b0;
      end
      if (p_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_word_i.kind == tgms_pkg::KIND_RD_C)) begin
      p_inside_q <= in_rng;
      p_row_q    <= in_word_i.row;
      p_col_q    <= in_word_i.col;
    end
    if (p_move) begin
      out_word_q.element <= p_inside_q ? r_rd_q : '0;
      out_word_q.out_row <= p_row_q;
      out_word_q.out_col <= p_col_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // mac results only come back while a compute is running
  a_wb_in_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag3.valid |-> (state_q != ST_IDLE) && (state_q != ST_CLEAR))
    else $error("mac write-back outside compute");

  // drain must finish all partial writes before the A' pass reads them
  a_f_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DMUL) |-> !(tag3.valid && (tag3.op == tgms_pkg::OP_F)))
    else $error("partial write overlaps second pass");

  // a pending read never overruns a stalled output word
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_valid_q && out_valid_q && out_stall_i) |=> p_valid_q && out_valid_q)
    else $error("read word lost");

endmodule

`default_nettype wire
